// ----- hw/rtl/face_group_labeler_defines.svh -----
// Assertion helpers for the RTL file that checks itself, face_group_labeler.sv.
// Both macros sample on aclk and are switched off while aresetn is low.
`ifndef FACE_GROUP_LABELER_DEFINES_SVH
`define FACE_GROUP_LABELER_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define FGL_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// When the trigger holds, the result must hold in the next clock cycle.
`define FGL_ASSERT_NEXT(label, trig, res, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (res)) \
        else $error(msg);

`endif

// ----- hw/rtl/fgl_pkg.sv -----
package fgl_pkg;

    // Field widths of the stream words.
    localparam int VERTEX_W   = 16;
    localparam int FACE_W     = 16;
    localparam int GROUP_ID_W = 12;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 32;

    // Vertex indices arrive with 16 bits, so no more entries than this are ever addressed.
    localparam int VERTEX_SPAN = 1 << VERTEX_W;

    // Default sizes.
    localparam int VERTEX_COUNT_DEF = 65536;
    localparam int GROUP_COUNT_DEF  = 4096;

    // Width of the mesh tag kept with every table entry.
    localparam int EPOCH_W = 8;

    function automatic int fgl_table_depth(input int vertex_count);
        return (vertex_count < VERTEX_SPAN) ? vertex_count : VERTEX_SPAN;
    endfunction

endpackage

// ----- hw/rtl/fgl_ram.sv -----
module fgl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/fgl_slot_unit.sv -----
// Reduces a vertex index to a table slot, one compare and subtract per cycle.
module fgl_slot_unit #(
    parameter int VERTEX_COUNT = fgl_pkg::VERTEX_COUNT_DEF
) (
    input  logic                                                      aclk,
    input  logic                                                      aresetn,
    input  logic                                                      start,
    input  logic [fgl_pkg::VERTEX_W-1:0]                              value,
    output logic                                                      ready,
    output logic                                                      done,
    output logic [$clog2(fgl_pkg::fgl_table_depth(VERTEX_COUNT))-1:0] slot
);
    import fgl_pkg::*;

    localparam int  DEPTH   = fgl_table_depth(VERTEX_COUNT);
    localparam int  AW      = $clog2(DEPTH);
    localparam bit  IS_POW2 = ((VERTEX_COUNT & (VERTEX_COUNT - 1)) == 0);
    localparam int  QMAX    = (VERTEX_SPAN + VERTEX_COUNT - 1) / VERTEX_COUNT;
    localparam int  STEPS   = (VERTEX_COUNT >= VERTEX_SPAN || IS_POW2) ? 0 : $clog2(QMAX);
    localparam int  SW      = (STEPS > 0) ? $clog2(STEPS + 1) : 1;
    localparam int  DW      = VERTEX_W + 2;
    localparam longint D0   = (STEPS > 0) ?
                              (longint'(VERTEX_COUNT) << (STEPS - 1)) : 64'd0;

    logic          busy_reg, busy_next;
    logic [SW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] div_reg, div_next;

    assign done  = busy_reg && (cnt_reg == '0);
    assign ready = !busy_reg || done;
    assign slot  = rem_reg[AW-1:0];

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start && ready) begin
            busy_next = 1'b1;
            cnt_next  = SW'(STEPS);
            rem_next  = DW'(value);
            div_next  = DW'(D0);
        end else if (busy_reg && cnt_reg != '0) begin
            // Restoring reduction: subtract the shifted modulus where it fits.
            if (rem_reg >= div_reg) begin
                rem_next = rem_reg - div_reg;
            end
            div_next = div_reg >> 1;
            cnt_next = cnt_reg - SW'(1);
        end else if (done) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

endmodule

// ----- hw/rtl/face_group_labeler.sv -----
// Channel | Direction | Word contents (lowest bits first)
// s_      | in        | tdata: vertex_a, vertex_b, vertex_c; tuser: mesh_start
// m_      | out       | tdata: face_number, group_id, new_group, group_overflow
//
// The slot unit takes S reduction steps per vertex, where S is zero when VERTEX_COUNT is
// a power of two or at least 65536, and ceil(log2(65536/VERTEX_COUNT)) otherwise.
// The slot unit handles the three vertices in turn; each read of the vertex table follows
// its slot, then three table writes go out one per cycle on the memory's write port.
// After reset, and on every mesh start that wraps the mesh tag (one in 255), a clearing
// pass writes every one of the min(VERTEX_COUNT, 65536) table entries, with s_tready low.
// A finished word waits in the output register; the next face is accepted meanwhile,
// and only its own completion stalls while m_tready stays low.
module face_group_labeler #(
    parameter int VERTEX_COUNT = fgl_pkg::VERTEX_COUNT_DEF,
    parameter int GROUP_COUNT  = fgl_pkg::GROUP_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [15:0] vertex_a, [31:16] vertex_b, [47:32] vertex_c
    input  logic [fgl_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] mesh_start
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [15:0] face_number, [27:16] group_id, [28] new_group, [29] group_overflow, rest zero
    output logic [fgl_pkg::M_TDATA_W-1:0] m_tdata
);
    import fgl_pkg::*;

    `include "face_group_labeler_defines.svh"

    localparam int DEPTH = fgl_table_depth(VERTEX_COUNT);
    localparam int AW    = $clog2(DEPTH);
    localparam int GW    = $clog2(GROUP_COUNT);
    localparam int CW    = $clog2(GROUP_COUNT + 1);
    localparam int EW    = EPOCH_W + GW;
    localparam int PAD_W = M_TDATA_W - FACE_W - GROUP_ID_W - 2;

    // Sequencer states.
    typedef enum logic [5:0] {
        ST_CLEAR   = 6'b000001,  // writing every table entry to zero
        ST_IDLE    = 6'b000010,  // waiting for a face
        ST_REDUCE  = 6'b000100,  // slots computed and table read, vertex by vertex
        ST_RESOLVE = 6'b001000,  // pick the face's group
        ST_WRITE   = 6'b010000,  // write the group to the three slots
        ST_DONE    = 6'b100000   // hand the result to the output register
    } state_t;

    state_t                state_reg, state_next;
    logic [VERTEX_W-1:0]   vtx_reg [0:2];
    logic [VERTEX_W-1:0]   vtx_next [0:2];
    logic [AW-1:0]         slot_reg [0:2];
    logic [AW-1:0]         slot_next [0:2];
    logic [1:0]            start_idx_reg, start_idx_next;
    logic [1:0]            done_idx_reg, done_idx_next;
    logic [1:0]            chk_idx_reg, chk_idx_next;
    logic [1:0]            widx_reg, widx_next;
    logic                  rd_valid_reg, rd_valid_next;
    logic                  found_reg, found_next;
    logic [GW-1:0]         hit_grp_reg, hit_grp_next;
    logic [GW-1:0]         grp_reg, grp_next;
    logic                  opened_reg, opened_next;
    logic                  ovf_reg, ovf_next;
    logic [CW-1:0]         gcnt_reg, gcnt_next;
    logic [FACE_W-1:0]     face_cnt_reg, face_cnt_next;
    logic [EPOCH_W-1:0]    epoch_reg, epoch_next;
    logic [AW-1:0]         clr_cnt_reg, clr_cnt_next;
    logic                  pend_reg, pend_next;
    logic                  m_valid_reg, m_valid_next;
    logic [FACE_W-1:0]     out_face_reg, out_face_next;
    logic [GROUP_ID_W-1:0] out_grp_reg, out_grp_next;
    logic                  out_new_reg, out_new_next;
    logic                  out_ovf_reg, out_ovf_next;

    // Slot unit and table ports.
    logic                unit_start;
    logic [VERTEX_W-1:0] unit_value;
    logic                unit_ready;
    logic                unit_done;
    logic [AW-1:0]       unit_slot;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [EW-1:0]       ram_wdata;
    logic [EW-1:0]       ram_rdata;

    logic                in_fire;
    logic                out_free;
    logic [VERTEX_W-1:0] grp_wide;

    fgl_slot_unit #(
        .VERTEX_COUNT(VERTEX_COUNT)
    ) u_slot (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (unit_start),
        .value  (unit_value),
        .ready  (unit_ready),
        .done   (unit_done),
        .slot   (unit_slot)
    );

    // Each entry holds the mesh tag it was written under and its group. An entry is
    // valid only when its tag equals the current tag; tag zero never is current.
    fgl_ram #(
        .WIDTH(EW),
        .DEPTH(DEPTH)
    ) u_table (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_addr(unit_slot),
        .rd_data(ram_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {PAD_W'(0), out_ovf_reg, out_new_reg, out_grp_reg, out_face_reg};
    assign grp_wide = VERTEX_W'(grp_reg);

    // The slot unit takes the vertices in order a, b, c.
    assign unit_start = (state_reg == ST_REDUCE) && (start_idx_reg != 2'd3) && unit_ready;
    always_comb begin
        case (start_idx_reg)
            2'd0:    unit_value = vtx_reg[0];
            2'd1:    unit_value = vtx_reg[1];
            default: unit_value = vtx_reg[2];
        endcase
    end

    // Table writes come from the clearing pass or from the group write-back.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = clr_cnt_reg;
        ram_wdata = '0;
        if (state_reg == ST_CLEAR) begin
            ram_we = 1'b1;
        end else if (state_reg == ST_WRITE) begin
            ram_we    = 1'b1;
            ram_waddr = slot_reg[widx_reg];
            ram_wdata = {epoch_reg, grp_reg};
        end
    end

    always_comb begin
        state_next     = state_reg;
        vtx_next       = vtx_reg;
        slot_next      = slot_reg;
        start_idx_next = start_idx_reg;
        done_idx_next  = done_idx_reg;
        chk_idx_next   = chk_idx_reg;
        widx_next      = widx_reg;
        rd_valid_next  = 1'b0;
        found_next     = found_reg;
        hit_grp_next   = hit_grp_reg;
        grp_next       = grp_reg;
        opened_next    = opened_reg;
        ovf_next       = ovf_reg;
        gcnt_next      = gcnt_reg;
        face_cnt_next  = face_cnt_reg;
        epoch_next     = epoch_reg;
        clr_cnt_next   = clr_cnt_reg;
        pend_next      = pend_reg;
        m_valid_next   = m_valid_reg;
        out_face_next  = out_face_reg;
        out_grp_next   = out_grp_reg;
        out_new_next   = out_new_reg;
        out_ovf_next   = out_ovf_reg;

        // The output register drains independently of the sequencer.
        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                    clr_cnt_next = '0;
                    pend_next    = 1'b0;
                    state_next   = pend_reg ? ST_REDUCE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    vtx_next[0]    = s_tdata[VERTEX_W-1:0];
                    vtx_next[1]    = s_tdata[2*VERTEX_W-1:VERTEX_W];
                    vtx_next[2]    = s_tdata[3*VERTEX_W-1:2*VERTEX_W];
                    start_idx_next = '0;
                    done_idx_next  = '0;
                    chk_idx_next   = '0;
                    found_next     = 1'b0;
                    state_next     = ST_REDUCE;
                    if (s_tuser) begin
                        // A new mesh: counters restart and the tag moves on, which
                        // retires every entry of the previous mesh at once. When the
                        // tag would wrap, the table is swept clean first.
                        gcnt_next     = '0;
                        face_cnt_next = '0;
                        if (epoch_reg == '1) begin
                            epoch_next = EPOCH_W'(1);
                            pend_next  = 1'b1;
                            state_next = ST_CLEAR;
                        end else begin
                            epoch_next = epoch_reg + EPOCH_W'(1);
                        end
                    end
                end
            end
            ST_REDUCE: begin
                if (unit_start) begin
                    start_idx_next = start_idx_reg + 2'd1;
                end
                if (unit_done) begin
                    // The table read for this slot goes out in the same cycle.
                    slot_next[done_idx_reg] = unit_slot;
                    done_idx_next           = done_idx_reg + 2'd1;
                    rd_valid_next           = 1'b1;
                end
                if (rd_valid_reg) begin
                    // Reads return in vertex order, so the first hit wins.
                    if (!found_reg && ram_rdata[EW-1:GW] == epoch_reg) begin
                        found_next   = 1'b1;
                        hit_grp_next = ram_rdata[GW-1:0];
                    end
                    chk_idx_next = chk_idx_reg + 2'd1;
                    if (chk_idx_reg == 2'd2) begin
                        state_next = ST_RESOLVE;
                    end
                end
            end
            ST_RESOLVE: begin
                opened_next = 1'b0;
                ovf_next    = 1'b0;
                if (found_reg) begin
                    grp_next = hit_grp_reg;
                end else if (gcnt_reg < CW'(GROUP_COUNT)) begin
                    grp_next    = GW'(gcnt_reg);
                    gcnt_next   = gcnt_reg + CW'(1);
                    opened_next = 1'b1;
                end else begin
                    // Group space used up: saturate at the last group.
                    grp_next = GW'(GROUP_COUNT - 1);
                    ovf_next = 1'b1;
                end
                widx_next  = '0;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                widx_next = widx_reg + 2'd1;
                if (widx_reg == 2'd2) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    out_face_next = face_cnt_reg;
                    out_grp_next  = grp_wide[GROUP_ID_W-1:0];
                    out_new_next  = opened_reg;
                    out_ovf_next  = ovf_reg;
                    face_cnt_next = face_cnt_reg + FACE_W'(1);
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            pend_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
            gcnt_reg      <= '0;
            face_cnt_reg  <= '0;
            epoch_reg     <= EPOCH_W'(1);
            rd_valid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            pend_reg      <= pend_next;
            m_valid_reg   <= m_valid_next;
            gcnt_reg      <= gcnt_next;
            face_cnt_reg  <= face_cnt_next;
            epoch_reg     <= epoch_next;
            rd_valid_reg  <= rd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        vtx_reg       <= vtx_next;
        slot_reg      <= slot_next;
        start_idx_reg <= start_idx_next;
        done_idx_reg  <= done_idx_next;
        chk_idx_reg   <= chk_idx_next;
        widx_reg      <= widx_next;
        found_reg     <= found_next;
        hit_grp_reg   <= hit_grp_next;
        grp_reg       <= grp_next;
        opened_reg    <= opened_next;
        ovf_reg       <= ovf_next;
        out_face_reg  <= out_face_next;
        out_grp_reg   <= out_grp_next;
        out_new_reg   <= out_new_next;
        out_ovf_reg   <= out_ovf_next;
    end

    // A word never claims both a new group and an exhausted group space.
    `FGL_ASSERT_ALWAYS(a_new_vs_ovf, !(m_valid_reg && out_new_reg && out_ovf_reg), "new_group with overflow")
    // The group counter never passes the number of groups.
    `FGL_ASSERT_ALWAYS(a_gcnt_bound, gcnt_reg <= CW'(GROUP_COUNT), "group counter beyond range")
    // Tag zero marks cleared entries and must never be the current tag.
    `FGL_ASSERT_ALWAYS(a_epoch_nonzero, epoch_reg != '0, "current mesh tag is zero")
    // A face with no grouped vertex and room left takes the next group number.
    `FGL_ASSERT_NEXT(a_gcnt_step, state_reg == ST_RESOLVE && !found_reg && gcnt_reg < CW'(GROUP_COUNT), gcnt_reg == $past(gcnt_reg) + CW'(1) && opened_reg, "group counter did not advance")

endmodule

// ----- verif/face_group_labeler_tb.sv -----
module face_group_labeler_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 12;
    localparam int VERTEX_COUNT = fgl_pkg::VERTEX_COUNT_DEF;
    localparam int GROUP_COUNT  = fgl_pkg::GROUP_COUNT_DEF;

    localparam int RANDOM_FACES   = 264;
    // Enough mesh starts to carry the mesh tag of the block past its wrap point, so the
    // table has to be swept clean a second time during the run.
    localparam int RESTART_MESHES = 260;

    // The slowest correct run is dominated by two table clearing passes over every entry;
    // the 800 or so faces with stalls and the long hold-off add far less. The limit is
    // several times that.
    localparam int CYCLE_LIMIT = 1_000_000;

    // One result word, laid out as it appears in m_tdata[29:0].
    typedef struct packed {
        logic                            group_overflow;
        logic                            new_group;
        logic [fgl_pkg::GROUP_ID_W-1:0]  group_id;
        logic [fgl_pkg::FACE_W-1:0]      face_number;
    } face_label_t;

    // A label typed in by hand replaces the predicted one for the same face.
    typedef struct packed {
        logic        fixed;
        face_label_t word;
    } pinned_label_t;

    typedef struct {
        logic [15:0] va;
        logic [15:0] vb;
        logic [15:0] vc;
        logic        start;
        logic        fixed;
        logic [15:0] face;
        logic [11:0] grp_id;
        logic        opened;
        logic        ovf;
    } face_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [fgl_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [fgl_pkg::M_TDATA_W-1:0] m_tdata;

    // Idle rates in percent of cycles; the stimulus flow changes them between phases.
    int unsigned tx_idle_pct = 13;
    int unsigned rx_idle_pct = 54;

    // Predictor state: a slot that is present in the map carries a group, every other
    // slot has none. Deleting the whole map is the same as marking every entry invalid.
    int unsigned vertex_group [int unsigned];
    int unsigned groups_issued = 0;
    logic [15:0] face_count    = '0;

    face_label_t   label_q [$];
    pinned_label_t pin_q [$];
    int unsigned   faces_accepted = 0;
    int unsigned   mismatches     = 0;

    // Random vertices mostly come from a window of 48 indices so that faces share
    // vertices and pick up existing groups; the rest are 0, 0xFFFF or any index.
    logic [15:0] pool_base = '0;

    // Directed faces, walked in order right after reset. Labels are typed in where they
    // are plain to see; the other rows rely on the predictor.
    // Columns: a, b, c, mesh start, label typed in, face, group, new group, overflow.
    face_row_t directed_rows [16] = '{
        // The first face after reset finds an empty table and opens group 0.
        '{16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, 16'd0, 12'd0, 1'b1, 1'b0},
        // Top vertex index, repeated three times.
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 16'd1, 12'd1, 1'b1, 1'b0},
        // The first vertex already has a group.
        '{16'h0000, 16'h0001, 16'h0002, 1'b0, 1'b1, 16'd2, 12'd0, 1'b0, 1'b0},
        // Only the third vertex has a group.
        '{16'h0003, 16'h0004, 16'hFFFF, 1'b0, 1'b1, 16'd3, 12'd1, 1'b0, 1'b0},
        // The second vertex decides, and vertex 0 moves to the other group.
        '{16'h0005, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 16'd0, 12'd0, 1'b0, 1'b0},
        '{16'h0000, 16'h0001, 16'h0002, 1'b0, 1'b0, 16'd0, 12'd0, 1'b0, 1'b0},
        '{16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, 1'b0, 16'd0, 12'd0, 1'b0, 1'b0},
        '{16'h5555, 16'hAAAA, 16'h5555, 1'b0, 1'b0, 16'd0, 12'd0, 1'b0, 1'b0},
        '{16'h0007, 16'h0007, 16'h0007, 1'b0, 1'b0, 16'd0, 12'd0, 1'b0, 1'b0},
        // A mesh start retires the table entries and resets both counters before the lookup.
        '{16'hFFFF, 16'h0000, 16'h0001, 1'b1, 1'b1, 16'd0, 12'd0, 1'b1, 1'b0},
        '{16'h0000, 16'h0001, 16'h0002, 1'b0, 1'b1, 16'd1, 12'd0, 1'b0, 1'b0},
        '{16'd100,  16'd200,  16'd300,  1'b0, 1'b1, 16'd2, 12'd1, 1'b1, 1'b0},
        '{16'h8000, 16'h7FFF, 16'h0001, 1'b0, 1'b0, 16'd0, 12'd0, 1'b0, 1'b0},
        '{16'h0001, 16'h8000, 16'd300,  1'b0, 1'b0, 16'd0, 12'd0, 1'b0, 1'b0},
        // A mesh start on a face whose vertices were all in use before.
        '{16'd100,  16'd100,  16'd100,  1'b1, 1'b1, 16'd0, 12'd0, 1'b1, 1'b0},
        '{16'd200,  16'd300,  16'd100,  1'b0, 1'b0, 16'd0, 12'd0, 1'b0, 1'b0}
    };

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    face_group_labeler #(
        .VERTEX_COUNT (VERTEX_COUNT),
        .GROUP_COUNT  (GROUP_COUNT)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Works out the label of one face and updates the vertex map and the counters the
    // way the block does. The group of the first labeled vertex in the order a, b, c
    // wins; without one a fresh group is issued, or the last group once all are used.
    function automatic face_label_t label_face(input logic [15:0] va, input logic [15:0] vb,
                                               input logic [15:0] vc, input logic start);
        int unsigned slot [3];
        int unsigned grp;
        bit          found;
        face_label_t res;
        if (start) begin
            vertex_group.delete();
            groups_issued = 0;
            face_count    = '0;
        end
        slot[0] = va % VERTEX_COUNT;
        slot[1] = vb % VERTEX_COUNT;
        slot[2] = vc % VERTEX_COUNT;
        found   = 1'b0;
        grp     = 0;
        res     = '0;
        foreach (slot[i]) begin
            if (!found && vertex_group.exists(slot[i])) begin
                grp   = vertex_group[slot[i]];
                found = 1'b1;
            end
        end
        if (!found) begin
            if (groups_issued < GROUP_COUNT) begin
                grp = groups_issued;
                groups_issued++;
                res.new_group = 1'b1;
            end else begin
                grp = GROUP_COUNT - 1;
                res.group_overflow = 1'b1;
            end
        end
        foreach (slot[i]) vertex_group[slot[i]] = grp;
        res.face_number = face_count;
        res.group_id    = grp[fgl_pkg::GROUP_ID_W-1:0];
        face_count++;
        return res;
    endfunction

    function automatic logic [15:0] pick_vertex();
        case ($urandom_range(9)) inside
            0: return {16{1'($urandom_range(1))}};
            1, 2: return 16'($urandom);
            default: return pool_base + 16'($urandom_range(47));
        endcase
    endfunction

    // Presents one face and returns right after the clock edge that accepted it. The valid
    // line is left high, so the next face follows back to back unless the sender idles.
    task automatic offer_face(input logic [15:0] va, input logic [15:0] vb,
                              input logic [15:0] vc, input logic start,
                              input logic fixed, input face_label_t want);
        pinned_label_t entry;
        entry.fixed = fixed;
        entry.word  = want;
        pin_q = {pin_q, entry};
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {vc, vb, va};
        s_tuser  <= start;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // A new mesh now and then moves the vertex window, so groups keep being opened.
    task automatic offer_random_face();
        logic start;
        start = ($urandom_range(49) == 0);
        if (start) pool_base = 16'($urandom);
        offer_face(pick_vertex(), pick_vertex(), pick_vertex(), start, 1'b0, '0);
    endtask

    // Every accepted input word is labeled at once, in acceptance order.
    always @(posedge aclk) begin : accept_side
        pinned_label_t pin;
        face_label_t   word;
        if (aresetn && s_tvalid && s_tready) begin
            pin  = pin_q.pop_front();
            word = label_face(s_tdata[15:0], s_tdata[31:16], s_tdata[47:32], s_tuser);
            if (pin.fixed) word = pin.word;
            label_q = {label_q, word};
            faces_accepted++;
        end
    end

    // Every result word is held against the oldest label still waiting.
    always @(posedge aclk) begin : result_side
        face_label_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (label_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result word %h arrived with no face waiting", $time, m_tdata);
            end else begin
                want = label_q.pop_front();
                if (m_tdata[15:0]  !== want.face_number || m_tdata[27:16] !== want.group_id ||
                    m_tdata[28]    !== want.new_group   ||
                    m_tdata[29]    !== want.group_overflow ||
                    m_tdata[31:30] !== 2'b00) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: face %0d group %0d new %0b overflow %0b expected, ",
                                  "got face %0d group %0d new %0b overflow %0b pad %b"},
                                 $time, want.face_number, want.group_id, want.new_group,
                                 want.group_overflow, m_tdata[15:0], m_tdata[27:16],
                                 m_tdata[28], m_tdata[29], m_tdata[31:30]);
                end
            end
        end
    end

    // The receiver stalls at random. Once, early in the run, it holds off for a long
    // stretch while faces keep coming, so the output register and the face in flight
    // back up and the block has to drop s_tready.
    int unsigned hold_cycles_left = 0;
    bit          hold_done        = 1'b0;

    always @(posedge aclk) begin
        if (hold_cycles_left > 0) begin
            m_tready         <= 1'b0;
            hold_cycles_left <= hold_cycles_left - 1;
        end else if (!hold_done && faces_accepted >= 60) begin
            hold_done        <= 1'b1;
            hold_cycles_left <= 400;
            m_tready         <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        face_label_t want;
        int          k;

        // After reset is released, the block clears its table, with s_tready low, before it
        // takes the first face.
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[r]) begin
            want.face_number    = directed_rows[r].face;
            want.group_id       = directed_rows[r].grp_id;
            want.new_group      = directed_rows[r].opened;
            want.group_overflow = directed_rows[r].ovf;
            offer_face(directed_rows[r].va, directed_rows[r].vb, directed_rows[r].vc,
                       directed_rows[r].start, directed_rows[r].fixed, want);
        end

        // Random faces with a slow receiver; the long hold-off falls in here.
        for (k = 0; k < RANDOM_FACES / 3; k++) offer_random_face();

        // Now the sender is the slow side.
        tx_idle_pct = 54;
        rx_idle_pct = 13;
        for (k = 0; k < RANDOM_FACES / 3; k++) offer_random_face();

        // Many short meshes, mostly over one small set of vertices. Each mesh must start from
        // an empty table, so a vertex labeled in an earlier mesh must never leak into a
        // later one, also across the point where the block has to clear its table again.
        pool_base = 16'($urandom);
        for (k = 0; k < RESTART_MESHES; k++) begin
            offer_face(pick_vertex(), pick_vertex(), pick_vertex(), 1'b1, 1'b0, '0);
            offer_face(pick_vertex(), pick_vertex(), pick_vertex(), 1'b0, 1'b0, '0);
        end

        // Neither side idles from here on.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (k = 0; k < RANDOM_FACES - 2 * (RANDOM_FACES / 3); k++) offer_random_face();
        s_tvalid <= 1'b0;

        // Drain the last labels, then give a stray extra word time to show up.
        while (label_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (mismatches == 0 && label_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
